// ----- src/gmcp_pkg.sv -----
// shared constants and control types for the grid minimum-cost path block
package gmcp_pkg;

	localparam int CELL_W       = 4;
	localparam int COST_W       = 12;
	localparam int COLS_W       = 7;
	localparam int GRID_ROWS    = 3;
	localparam int MAX_COLS_DEF = 64;

	localparam logic [COLS_W-1:0] COLS_RESET = 7'd64;
	localparam logic [COST_W-1:0] COST_INF   = 12'hFFF;

	// top level to solver
	typedef struct packed {
		logic start;
		logic res_free;
	} gmcp_ctl_t;

	// solver to top level
	typedef struct packed {
		logic busy;
		logic res_valid;
	} gmcp_sts_t;

endpackage

// ----- src/gmcp_if.sv -----
// valid/ready channels for grid cells and path costs
interface gmcp_cell_if;
	import gmcp_pkg::*;
	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] cell_value;
	logic              last_cell;

	modport source (output valid, output cell_value, output last_cell, input ready);
	modport sink   (input valid, input cell_value, input last_cell, output ready);
endinterface

interface gmcp_cost_if;
	import gmcp_pkg::*;
	logic              valid;
	logic              ready;
	logic [COST_W-1:0] path_cost;

	modport source (output valid, output path_cost, input ready);
	modport sink   (input valid, input path_cost, output ready);
endinterface

// ----- src/gmcp_cell_mem.sv -----
// grid cell store, one write port and one registered read port
module gmcp_cell_mem
	import gmcp_pkg::*;
#(
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [$clog2(GRID_ROWS*MAX_COLS)-1:0]     waddr,
	input  logic [CELL_W-1:0]                         wdata,
	input  logic [$clog2(GRID_ROWS*MAX_COLS)-1:0]     raddr,
	output logic [CELL_W-1:0]                         rdata
);

	localparam int DEPTH = GRID_ROWS * MAX_COLS;

	logic [CELL_W-1:0] mem_q [DEPTH];
	logic [CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/gmcp_solver.sv -----
// relaxation sequencer with cost store and one shared add/compare unit
module gmcp_solver
	import gmcp_pkg::*;
#(
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  gmcp_ctl_t                             ctl,
	input  logic [COLS_W-1:0]                     col_count,
	output logic [$clog2(GRID_ROWS*MAX_COLS)-1:0] cell_raddr,
	input  logic [CELL_W-1:0]                     cell_rdata,
	output gmcp_sts_t                             sts,
	output logic [COST_W-1:0]                     result
);

	localparam int DEPTH = GRID_ROWS * MAX_COLS;
	localparam int IW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_COLS + 1);
	localparam int CCW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	localparam logic [2:0] NB_RIGHT = 3'd0;
	localparam logic [2:0] NB_DOWN  = 3'd1;
	localparam logic [2:0] NB_LEFT  = 3'd2;
	localparam logic [2:0] NB_UP    = 3'd3;
	localparam logic [2:0] NB_DONE  = 3'd4;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_BASE   = 8'b0000_0010,
		ST_INIT   = 8'b0000_0100,
		ST_SELF   = 8'b0000_1000,
		ST_NB     = 8'b0001_0000,
		ST_WR     = 8'b0010_0000,
		ST_FIN_RD = 8'b0100_0000,
		ST_FIN    = 8'b1000_0000
	} gmcp_state_t;

	gmcp_state_t       state_q;
	logic [IW-1:0]     idx_q;
	logic [1:0]        row_q;
	logic [CCW-1:0]    col_q;
	logic [CW-1:0]     cols_q;
	logic [IW-1:0]     last_idx_q;
	logic [CELL_W-1:0] base_q;
	logic [CELL_W-1:0] ec_q;
	logic [COST_W-1:0] best_q;
	logic              imp_q;
	logic              changed_q;
	logic [2:0]        nb_q;
	logic              nv_s1;

	logic [COST_W-1:0] cost_mem_q [DEPTH];
	logic [COST_W-1:0] cost_rd_q;

	logic [CW-1:0]     cols_clamp;
	logic [IW:0]       cells_total;
	logic              has_right;
	logic              has_down;
	logic              has_left;
	logic              has_up;
	logic              nb_ok;
	logic [IW-1:0]     nb_addr;
	logic [COST_W:0]   cand;
	logic              cost_we;
	logic [COST_W-1:0] cost_wdata;
	logic [IW-1:0]     cost_raddr;
	logic              col_wrap;

	function automatic logic [CELL_W-1:0] abs_diff(input logic [CELL_W-1:0] a,
	                                               input logic [CELL_W-1:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

	// column count of zero runs as one, anything above the store width is capped
	always_comb begin
		if (col_count == '0) begin
			cols_clamp = CW'(1);
		end else if (col_count > COLS_W'(MAX_COLS)) begin
			cols_clamp = CW'(MAX_COLS);
		end else begin
			cols_clamp = CW'(col_count);
		end
		cells_total = (IW+1)'(cols_clamp) + (IW+1)'(cols_clamp) + (IW+1)'(cols_clamp);
	end

	assign has_right = (CW'(col_q) + CW'(1)) < cols_q;
	assign has_down  = row_q != 2'(GRID_ROWS - 1);
	assign has_left  = col_q != '0;
	assign has_up    = row_q != '0;
	assign col_wrap  = (CW'(col_q) + CW'(1)) == cols_q;

	always_comb begin
		case (nb_q)
			NB_RIGHT: begin
				nb_ok   = has_right;
				nb_addr = idx_q + IW'(1);
			end
			NB_DOWN: begin
				nb_ok   = has_down;
				nb_addr = idx_q + IW'(cols_q);
			end
			NB_LEFT: begin
				nb_ok   = has_left;
				nb_addr = idx_q - IW'(1);
			end
			NB_UP: begin
				nb_ok   = has_up;
				nb_addr = idx_q - IW'(cols_q);
			end
			default: begin
				nb_ok   = 1'b0;
				nb_addr = idx_q;
			end
		endcase
	end

	// pull form: this cell's cost against neighbour cost plus this cell's entry cost
	assign cand = {1'b0, cost_rd_q} + (COST_W+1)'(ec_q);

	always_comb begin
		cost_we    = 1'b0;
		cost_wdata = best_q;
		case (state_q)
			ST_INIT: begin
				cost_we    = 1'b1;
				cost_wdata = (idx_q == '0) ? '0 : COST_INF;
			end
			ST_WR: begin
				cost_we = imp_q;
			end
			default: begin
				cost_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			ST_SELF: cost_raddr = idx_q;
			ST_NB:   cost_raddr = nb_addr;
			default: cost_raddr = last_idx_q;
		endcase
	end

	assign cell_raddr = (state_q == ST_BASE) ? '0 : idx_q;

	always_ff @(posedge clk) begin
		if (cost_we) begin
			cost_mem_q[idx_q] <= cost_wdata;
		end
		cost_rd_q <= cost_mem_q[cost_raddr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_INIT: begin
				if (idx_q == '0) begin
					base_q <= cell_rdata;
				end
			end
			ST_NB: begin
				if (nb_q == NB_RIGHT) begin
					best_q <= cost_rd_q;
					ec_q   <= abs_diff(cell_rdata, base_q);
				end else if (nv_s1 && (cand < {1'b0, best_q})) begin
					best_q <= cand[COST_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			row_q      <= '0;
			col_q      <= '0;
			cols_q     <= CW'(1);
			last_idx_q <= '0;
			imp_q      <= 1'b0;
			changed_q  <= 1'b0;
			nb_q       <= NB_RIGHT;
			nv_s1      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						cols_q     <= cols_clamp;
						last_idx_q <= IW'(cells_total - (IW+1)'(1));
						idx_q      <= '0;
						state_q    <= ST_BASE;
					end
				end
				ST_BASE: begin
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					if (idx_q == last_idx_q) begin
						idx_q     <= '0;
						row_q     <= '0;
						col_q     <= '0;
						changed_q <= 1'b0;
						state_q   <= ST_SELF;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_SELF: begin
					nb_q    <= NB_RIGHT;
					state_q <= ST_NB;
				end
				ST_NB: begin
					nv_s1 <= nb_ok;
					if (nb_q == NB_RIGHT) begin
						imp_q <= 1'b0;
					end else if (nv_s1 && (cand < {1'b0, best_q})) begin
						imp_q <= 1'b1;
					end
					if (nb_q == NB_DONE) begin
						state_q <= ST_WR;
					end else begin
						nb_q <= nb_q + 3'd1;
					end
				end
				ST_WR: begin
					if (idx_q == last_idx_q) begin
						idx_q <= '0;
						row_q <= '0;
						col_q <= '0;
						changed_q <= 1'b0;
						// another sweep only if this one lowered something
						state_q <= (changed_q || imp_q) ? ST_SELF : ST_FIN_RD;
					end else begin
						changed_q <= changed_q | imp_q;
						idx_q     <= idx_q + IW'(1);
						if (col_wrap) begin
							col_q <= '0;
							row_q <= row_q + 2'd1;
						end else begin
							col_q <= col_q + CCW'(1);
						end
						state_q <= ST_SELF;
					end
				end
				ST_FIN_RD: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (ctl.res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sts.busy      = state_q != ST_IDLE;
	assign sts.res_valid = (state_q == ST_FIN) && ctl.res_free;
	assign result        = cost_rd_q;

endmodule

// ----- src/grid_min_cost_path.sv -----
// Grid minimum-cost path. Cells of a 3-row grid arrive one word per cycle in row-major order
// and are written to the cell store; the word flagged last_cell starts the solve and the
// block then drops ready until the solve is done. The solve first initialises the cost
// store, then runs a relaxation sweep over every cell, sweeps repeating until one lowers
// no cost (at most 3*cols + 1 sweeps), then reads out the bottom-right cost. Each cell is
// relaxed by stepping the single cost store read port through a self read and four
// neighbour reads, then written back. A finished cost waits in an output register, so
// loading of the next grid carries on while it is unclaimed.
module grid_min_cost_path
	import gmcp_pkg::*;
#(
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [COLS_W-1:0] cfg_wdata,
	gmcp_cell_if.sink         grid,
	gmcp_cost_if.source       cost
);

	localparam int DEPTH = GRID_ROWS * MAX_COLS;
	localparam int IW    = $clog2(DEPTH);
	localparam int LCW   = $clog2(DEPTH + 1);

	logic [COLS_W-1:0] col_count_q;
	logic [LCW-1:0]    load_cnt_q;
	logic              out_valid_q;
	logic [COST_W-1:0] path_cost_q;

	gmcp_ctl_t         ctl;
	gmcp_sts_t         sts;
	logic              accept;
	logic              cell_we;
	logic [IW-1:0]     cell_raddr;
	logic [CELL_W-1:0] cell_rdata;
	logic [COST_W-1:0] result;

	assign grid.ready   = !sts.busy;
	assign accept       = grid.valid && grid.ready;
	// cells past the end of the store are dropped
	assign cell_we      = accept && (load_cnt_q < LCW'(DEPTH));
	assign ctl.start    = accept && grid.last_cell;
	assign ctl.res_free = !out_valid_q || cost.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= COLS_RESET;
			load_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				col_count_q <= cfg_wdata;
			end
			if (accept) begin
				if (grid.last_cell) begin
					load_cnt_q <= '0;
				end else if (cell_we) begin
					load_cnt_q <= load_cnt_q + LCW'(1);
				end
			end
			if (sts.res_valid) begin
				out_valid_q <= 1'b1;
			end else if (cost.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sts.res_valid) begin
			path_cost_q <= result;
		end
	end

	assign cost.valid     = out_valid_q;
	assign cost.path_cost = path_cost_q;

	gmcp_cell_mem #(
		.MAX_COLS (MAX_COLS)
	) u_cell_mem (
		.clk   (clk),
		.we    (cell_we),
		.waddr (load_cnt_q[IW-1:0]),
		.wdata (grid.cell_value),
		.raddr (cell_raddr),
		.rdata (cell_rdata)
	);

	gmcp_solver #(
		.MAX_COLS (MAX_COLS)
	) u_solver (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.col_count  (col_count_q),
		.cell_raddr (cell_raddr),
		.cell_rdata (cell_rdata),
		.sts        (sts),
		.result     (result)
	);

endmodule

// ----- src/gmcp_checker.sv -----
// port-level checks on the grid minimum-cost path block, bound to its top level
module gmcp_checker
	import gmcp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              grid_valid,
	input logic              grid_ready,
	input logic              grid_last_cell,
	input logic              cost_valid,
	input logic              cost_ready,
	input logic [COST_W-1:0] path_cost
);

	// a stalled cost word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		cost_valid && !cost_ready |=> cost_valid && $stable(path_cost))
	else $error("cost word changed or dropped while stalled");

	// a last cell starts the solve, so the grid side closes straight after it
	assert property (@(posedge clk) disable iff (!arst_n)
		grid_valid && grid_ready && grid_last_cell |=> !grid_ready)
	else $error("grid still ready after last cell");

	// the grid side only closes because of a last cell
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(grid_ready) |-> $past(grid_valid && grid_last_cell))
	else $error("grid ready fell without a last cell");

	// the bottom-right cell is always reachable, so the cost never saturates
	assert property (@(posedge clk) disable iff (!arst_n)
		cost_valid |-> path_cost != COST_INF)
	else $error("path cost saturated");

endmodule

bind grid_min_cost_path gmcp_checker u_gmcp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.grid_valid     (grid.valid),
	.grid_ready     (grid.ready),
	.grid_last_cell (grid.last_cell),
	.cost_valid     (cost.valid),
	.cost_ready     (cost.ready),
	.path_cost      (cost.path_cost)
);
